@@ rtl/core/des_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the delayed echo subtractor core.
// ----------------------------------------------------------------------------
package des_pkg;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_DELAY  = 2'd1,
		REG_RATE   = 2'd2,
		REG_FACTOR = 2'd3
	} reg_idx_t;

	localparam int CFG_DW = 16;

	// configuration limits and reset values
	localparam logic [9:0]  DELAY_MAX     = 10'd1000;
	localparam logic [15:0] FACTOR_MAX    = 16'd32768;
	localparam logic [9:0]  DELAY_RST     = 10'd100;
	localparam logic [15:0] RATE_RST      = 16'd48000;
	localparam logic [15:0] FACTOR_RST    = 16'd16384;

	// floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^26
	localparam logic [26:0] DIV_RECIP     = 27'd68719477;
	localparam int          DIV_SHIFT     = 36;

	// Q.30 gate threshold and full scale, Q0.15 smoothing weights
	localparam logic signed [32:0] GATE_Q30 = 33'sd10737418;
	localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;
	localparam logic signed [15:0] W_NEW    = 16'sd22938;
	localparam logic signed [15:0] W_OLD    = 16'sd9830;
	localparam logic signed [47:0] HALF_Q30 = 48'sd536870912;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADDR,
		ST_SUB,
		ST_GATE,
		ST_WGT,
		ST_FIN,
		ST_PASS
	} state_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic        enable;
		logic [9:0]  delay_ms;
		logic [15:0] rate_hz;
		logic [15:0] factor;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic push;
		logic do_mul;
		logic do_div;
		logic do_addr;
		logic do_sub;
		logic do_gate;
		logic do_wgt;
		logic do_fin;
		logic do_pass;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/des_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_regs
// Configuration registers with clamping and the history clear pulse.
// ----------------------------------------------------------------------------
module des_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  des_pkg::reg_idx_t          cfg_addr,
	input  logic [des_pkg::CFG_DW-1:0] cfg_wdata,
	output des_pkg::cfg_t              cfg,
	output logic                       clear
);
	import des_pkg::*;

	logic        enable_q;
	logic [9:0]  delay_q;
	logic [15:0] rate_q;
	logic [15:0] factor_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			delay_q  <= DELAY_RST;
			rate_q   <= RATE_RST;
			factor_q <= FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_DELAY:  delay_q  <= cfg_wdata[9:0];
				REG_RATE:   rate_q   <= cfg_wdata;
				REG_FACTOR: factor_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// any write of one to the enable clears history and smoothing state
	assign clear = cfg_we && (cfg_addr == REG_ENABLE) && cfg_wdata[0];

	// clamped view
	always_comb begin
		cfg.enable   = enable_q;
		cfg.delay_ms = (delay_q > DELAY_MAX) ? DELAY_MAX : delay_q;
		cfg.rate_hz  = rate_q;
		cfg.factor   = (factor_q > FACTOR_MAX) ? FACTOR_MAX : factor_q;
	end

endmodule

@@ rtl/core/des_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_ctrl
// Sequencer: accepts transactions and steps the datapath through a mic item.
// ----------------------------------------------------------------------------
module des_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           req_type,
	input  logic           enable,
	input  des_pkg::stat_t stat,
	output des_pkg::cmd_t  cmd
);
	import des_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (!req_type) begin
						cmd.push = enable;
					end else if (enable) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_PASS;
					end
				end
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.do_div = 1'b1;
				state_d    = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.do_addr = 1'b1;
				state_d     = ST_SUB;
			end
			ST_SUB: begin
				cmd.do_sub = 1'b1;
				state_d    = ST_GATE;
			end
			ST_GATE: begin
				cmd.do_gate = 1'b1;
				state_d     = ST_WGT;
			end
			ST_WGT: begin
				cmd.do_wgt = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.do_fin = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (stat.out_free) begin
					cmd.do_pass = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/des_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_dpath
// History memory, delay arithmetic, cancel, gate, smoothing and output slot.
// ----------------------------------------------------------------------------
module des_dpath #(
	parameter int HISTORY_DEPTH = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  des_pkg::cmd_t      cmd,
	output des_pkg::stat_t     stat,
	input  des_pkg::cfg_t      cfg,
	input  logic               clear,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] cleaned_sample
);
	import des_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int CW     = (ADDR_W > 16) ? ADDR_W : 16;
	localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0]     D_LIM    = CW'(HISTORY_DEPTH - 1);
	localparam logic [ADDR_W:0]   DEPTH_X  = (ADDR_W+1)'(HISTORY_DEPTH);

	logic [15:0]        mem [HISTORY_DEPTH];
	logic [ADDR_W-1:0]  wp_q;
	logic               wrapped_q;
	logic signed [15:0] last_q;
	logic signed [15:0] samp_q;
	logic [25:0]        prod_q;
	logic [15:0]        dly_q;
	logic [15:0]        rd_q;
	logic               hvalid_q;
	logic signed [32:0] e_q;
	logic signed [30:0] lw_q;
	logic signed [31:0] ec_q;
	logic signed [46:0] ew_q;
	logic               out_valid_q;
	logic signed [15:0] out_q;

	logic [52:0]        quo_full;
	logic [CW-1:0]      d_ext;
	logic [CW-1:0]      d_cap;
	logic [ADDR_W:0]    idx_sum;
	logic [ADDR_W-1:0]  rd_idx;
	logic signed [15:0] hist;
	logic signed [32:0] h_prod;
	logic signed [31:0] lw_full;
	logic signed [32:0] e_gate;
	logic signed [47:0] acc;
	logic signed [17:0] y;
	logic signed [15:0] y_sat;

	// write pointer and fill state of the history line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (clear) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.push) begin
			if (wp_q == LAST_POS) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// history memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp_q] <= sample;
		end
		if (cmd.do_addr) begin
			rd_q <= mem[rd_idx];
		end
	end

	// delay in samples, capped, and the read slot
	always_comb begin
		quo_full = 53'(prod_q) * 53'(DIV_RECIP);
		d_ext    = CW'(dly_q);
		d_cap    = (d_ext > D_LIM) ? D_LIM : d_ext;
		idx_sum  = (ADDR_W+1)'(wp_q) + (ADDR_W+1)'(LAST_POS) - (ADDR_W+1)'(d_cap[ADDR_W-1:0]);
		if (idx_sum >= DEPTH_X) begin
			idx_sum = idx_sum - DEPTH_X;
		end
		rd_idx = idx_sum[ADDR_W-1:0];
	end

	// entries never written since the last clear read as zero
	assign hist    = hvalid_q ? $signed(rd_q) : 16'sd0;
	assign h_prod  = 33'(hist) * $signed({17'b0, cfg.factor});
	assign lw_full = 32'(last_q) * 32'(W_OLD);

	// noise gate and clamp to full scale
	always_comb begin
		e_gate = e_q;
		if ((e_q > -GATE_Q30) && (e_q < GATE_Q30)) begin
			e_gate = '0;
		end
		if (e_gate > ONE_Q30) begin
			e_gate = ONE_Q30;
		end
		if (e_gate < -ONE_Q30) begin
			e_gate = -ONE_Q30;
		end
	end

	// smoothing sum, rounding and saturation
	always_comb begin
		acc = 48'(ew_q) + (48'(lw_q) <<< 15) + HALF_Q30;
		y   = 18'(acc >>> 30);
		if (y > 18'sd32767) begin
			y_sat = 16'sd32767;
		end else if (y < -18'sd32768) begin
			y_sat = -16'sd32768;
		end else begin
			y_sat = y[15:0];
		end
	end

	// arithmetic sequence registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			samp_q <= sample;
		end
		if (cmd.do_mul) begin
			prod_q <= 26'(cfg.delay_ms) * 26'(cfg.rate_hz);
		end
		if (cmd.do_div) begin
			dly_q <= quo_full[DIV_SHIFT+15:DIV_SHIFT];
		end
		if (cmd.do_addr) begin
			hvalid_q <= wrapped_q || (rd_idx < wp_q);
		end
		if (cmd.do_sub) begin
			e_q  <= $signed({samp_q[15], samp_q[15], samp_q, 15'b0}) - h_prod;
			lw_q <= lw_full[30:0];
		end
		if (cmd.do_gate) begin
			ec_q <= e_gate[31:0];
		end
		if (cmd.do_wgt) begin
			ew_q <= 47'(ec_q) * 47'(W_NEW);
		end
	end

	// smoothing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (clear) begin
			last_q <= '0;
		end else if (cmd.do_fin) begin
			last_q <= y_sat;
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_fin || cmd.do_pass) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_fin) begin
			out_q <= y_sat;
		end else if (cmd.do_pass) begin
			out_q <= samp_q;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign cleaned_sample = out_q;

	// checks
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_fin || cmd.do_pass) |-> stat.out_free)
		else $error("result loaded while output slot is occupied");

	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_fin || cmd.do_pass) |=> out_valid_q)
		else $error("loaded result not presented");

	a_push_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> cfg.enable)
		else $error("history written while cancellation disabled");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (wp_q == '0) && !wrapped_q && (last_q == 16'sd0))
		else $error("clear did not empty the history");

endmodule

@@ rtl/core/delayed_echo_subtractor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_echo_subtractor_core
// Echo canceller: subtracts a delayed, scaled playback sample from mic input.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, req_type, sample). A playback
//    transaction (req_type 0) is stored in the history line in the cycle it is
//    accepted while the canceller is enabled; one playback transaction can be
//    taken every cycle while the sequencer is idle.
//  - A mic transaction (req_type 1) runs through the sequencer: product of
//    delay and rate, reciprocal divide by 1000, history read, cancel multiply,
//    gate, weight multiply and final rounding, which loads the output register
//    once it is free; the next transaction is taken only after that step. With
//    the canceller disabled a mic sample goes into the output register in the
//    pass step, also once it is free, and the next is taken after that step.
//  - Output channel (out_valid/out_ready, cleaned_sample) is a register; a
//    stalled receiver holds the finished result, the next playback items are
//    still taken, and a following mic item waits at its final step.
//  - The user writes configuration (cfg_we, cfg_addr, cfg_wdata) while idle; the
//    block does not enforce it. Writing one to the enable register empties the
//    history and smoothing state at once; reset does too: no clearing pass needed.
// ----------------------------------------------------------------------------
module delayed_echo_subtractor_core #(
	parameter int HISTORY_DEPTH = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] cleaned_sample,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata
);
	import des_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;
	logic  clear;

	// configuration registers
	des_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (reg_idx_t'(cfg_addr)),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.clear     (clear)
	);

	// sequencer
	des_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.enable   (cfg.enable),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	des_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg),
		.clear          (clear),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cleaned_sample (cleaned_sample)
	);

endmodule
